// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file afrc_checker.sv.
// Each macro expects i_clk in the scope where it is used; all but AFRC_ASSERT_ALWAYS also expect i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define AFRC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("afrc check failed");

// Next-cycle implication, off while reset is held.
`define AFRC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("afrc check failed");

// Implication that is also checked during reset.
`define AFRC_ASSERT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |-> (cons)) \
        else $error("afrc check failed");

`endif

// ===== rtl/afrc_pkg.sv =====
// Shared constants, codes and types of the audio frame reassembly checker.
// No dependencies.
package afrc_pkg;

    localparam int MAX_CHUNK_DEF = 1024;
    localparam int HDR_BYTES     = 8;
    localparam int HDR_IDX_W     = 3;
    localparam int MIN_FRAME     = HDR_BYTES + 2;

    localparam logic [7:0] MAGIC_A = 8'h4A;  // 'J'
    localparam logic [7:0] MAGIC_B = 8'h41;  // 'A'

    // request kinds
    localparam logic [1:0] REQ_BEGIN = 2'd0;
    localparam logic [1:0] REQ_STOP  = 2'd1;
    localparam logic [1:0] REQ_DATA  = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    // result status codes
    localparam int         STATUS_W   = 4;
    localparam logic [3:0] ST_IGNORED = 4'd0;
    localparam logic [3:0] ST_TAKEN   = 4'd1;
    localparam logic [3:0] ST_READY   = 4'd2;
    localparam logic [3:0] ST_BOUNDS  = 4'd3;
    localparam logic [3:0] ST_DESYNC  = 4'd4;
    localparam logic [3:0] ST_MAGIC   = 4'd5;
    localparam logic [3:0] ST_STREAM  = 4'd6;
    localparam logic [3:0] ST_SEQ     = 4'd7;
    localparam logic [3:0] ST_STARTED = 4'd8;
    localparam logic [3:0] ST_STOPPED = 4'd9;
    localparam logic [3:0] ST_READ    = 4'd10;

    // stream port layout
    localparam int IN_USER_W  = 3;   // req_type, fragment_first
    localparam int IN_DATA_W  = 88;
    localparam int SEQ_W      = 32;
    localparam int BYTE_W     = 8;
    localparam int RIDX_W     = 10;

    // result queue in the back end
    localparam int QDEPTH  = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef struct packed {
        logic       valid;   // item accepted this cycle
        logic [3:0] status;
        logic       rd_hit;  // read request within the payload area
    } t_res_ctl;

endpackage

// ===== rtl/afrc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module afrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1032
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/afrc_front.sv =====
// Front end: classifies each accepted request, updates stream/fill state,
// drives the frame store ports. Depends on afrc_pkg.
module afrc_front #(
    parameter int MAX_CHUNK = afrc_pkg::MAX_CHUNK_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_acc,
    input  logic [1:0]                                 i_req_type,
    input  logic                                       i_fragment_first,
    input  logic [15:0]                                i_begin_stream_id,
    input  logic                                       i_playback_active,
    input  logic [15:0]                                i_fragment_offset,
    input  logic [15:0]                                i_fragment_length,
    input  logic [15:0]                                i_message_length,
    input  logic [7:0]                                 i_data_value,
    input  logic [afrc_pkg::RIDX_W-1:0]                i_read_index,
    output afrc_pkg::t_res_ctl                         o_ctl,
    output logic [$clog2(MAX_CHUNK+1)-1:0]             o_plen,
    output logic [afrc_pkg::SEQ_W-1:0]                 o_seq,
    output logic                                       o_we,
    output logic [$clog2(afrc_pkg::HDR_BYTES+MAX_CHUNK)-1:0] o_waddr,
    output logic [7:0]                                 o_wdata,
    output logic                                       o_re,
    output logic [$clog2(afrc_pkg::HDR_BYTES+MAX_CHUNK)-1:0] o_raddr
);

    localparam int STORE  = afrc_pkg::HDR_BYTES + MAX_CHUNK;
    localparam int FILL_W = $clog2(STORE + 1);
    localparam int ADDR_W = $clog2(STORE);
    localparam int PLEN_W = $clog2(MAX_CHUNK + 1);
    localparam int HDR    = afrc_pkg::HDR_BYTES;

    logic [FILL_W-1:0] r_fill, n_fill;
    logic [15:0]       r_frem, n_frem;
    logic [15:0]       r_active, n_active;
    logic [31:0]       r_nseq, n_nseq;
    logic [7:0]        r_hdr [HDR];
    logic [7:0]        n_hdr [HDR];

    logic [FILL_W-1:0] fill_eff, fill_nx;
    logic [15:0]       frem_eff, frem_nx;
    logic [16:0]       frag_end;
    logic [10:0]       rd_off;
    logic              take, abort_en;
    logic [3:0]        abort_code, status;
    logic [15:0]       hdr_sid;
    logic [31:0]       hdr_seq;

    always_comb begin
        n_fill     = r_fill;
        n_frem     = r_frem;
        n_active   = r_active;
        n_nseq     = r_nseq;
        n_hdr      = r_hdr;
        status     = afrc_pkg::ST_IGNORED;
        o_plen     = '0;
        o_seq      = '0;
        o_ctl      = '0;
        o_we       = 1'b0;
        o_re       = 1'b0;
        o_wdata    = i_data_value;
        take       = 1'b0;
        abort_en   = 1'b0;
        abort_code = afrc_pkg::ST_BOUNDS;
        fill_eff   = r_fill;
        frem_eff   = r_frem;
        fill_nx    = r_fill;
        frem_nx    = r_frem;
        frag_end   = '0;
        hdr_sid    = '0;
        hdr_seq    = '0;
        rd_off     = {1'b0, i_read_index} + 11'(HDR);
        o_raddr    = ADDR_W'(rd_off);

        case (i_req_type)
            afrc_pkg::REQ_BEGIN: begin
                if (i_begin_stream_id != 16'd0) begin
                    n_active = i_begin_stream_id;
                    n_nseq   = '0;
                    n_fill   = '0;
                    n_frem   = '0;
                    status   = afrc_pkg::ST_STARTED;
                end
            end
            afrc_pkg::REQ_STOP: begin
                n_active = '0;
                n_frem   = '0;
                status   = afrc_pkg::ST_STOPPED;
            end
            afrc_pkg::REQ_READ: begin
                status       = afrc_pkg::ST_READ;
                o_ctl.rd_hit = (int'(i_read_index) < MAX_CHUNK);
                o_re         = o_ctl.rd_hit;
            end
            default: begin
                if (i_fragment_first) begin
                    if (!i_playback_active || r_active == 16'd0) begin
                        n_frem = '0;
                    end else if (i_message_length < 16'(afrc_pkg::MIN_FRAME) ||
                                 i_message_length > 16'(STORE)) begin
                        abort_en = 1'b1;
                    end else begin
                        if (i_fragment_offset == 16'd0) begin
                            fill_eff = '0;
                        end
                        n_fill   = fill_eff;
                        frag_end = 17'(fill_eff) + 17'(i_fragment_length);
                        if (i_fragment_offset != 16'(fill_eff)) begin
                            abort_en   = 1'b1;
                            abort_code = afrc_pkg::ST_DESYNC;
                        end else if (frag_end > 17'(STORE)) begin
                            abort_en = 1'b1;
                        end else if (i_fragment_length != 16'd0) begin
                            frem_eff = i_fragment_length;
                            take     = 1'b1;
                        end
                    end
                end else if (r_frem != 16'd0) begin
                    take = 1'b1;
                end

                if (take) begin
                    if (fill_eff < FILL_W'(STORE)) begin
                        o_we    = 1'b1;
                        fill_nx = fill_eff + FILL_W'(1);
                        frem_nx = frem_eff - 16'd1;
                        n_fill  = fill_nx;
                        n_frem  = frem_nx;
                        status  = afrc_pkg::ST_TAKEN;
                        if (fill_eff < FILL_W'(HDR)) begin
                            n_hdr[fill_eff[afrc_pkg::HDR_IDX_W-1:0]] = i_data_value;
                        end
                        hdr_sid = {n_hdr[3], n_hdr[2]};
                        hdr_seq = {n_hdr[7], n_hdr[6], n_hdr[5], n_hdr[4]};
                        // fragment closes the frame: run the header checks
                        if (frem_nx == 16'd0 && 16'(fill_nx) >= i_message_length) begin
                            n_fill = '0;
                            if (n_hdr[0] != afrc_pkg::MAGIC_A ||
                                n_hdr[1] != afrc_pkg::MAGIC_B) begin
                                abort_en   = 1'b1;
                                abort_code = afrc_pkg::ST_MAGIC;
                            end else if (hdr_sid != r_active) begin
                                abort_en   = 1'b1;
                                abort_code = afrc_pkg::ST_STREAM;
                            end else if (hdr_seq != r_nseq) begin
                                abort_en   = 1'b1;
                                abort_code = afrc_pkg::ST_SEQ;
                            end else begin
                                n_nseq = r_nseq + 32'd1;
                                status = afrc_pkg::ST_READY;
                                o_plen = PLEN_W'(fill_nx - FILL_W'(HDR));
                                o_seq  = hdr_seq;
                            end
                        end
                    end else begin
                        abort_en = 1'b1;
                    end
                end

                if (abort_en) begin
                    n_active = '0;
                    n_fill   = '0;
                    n_frem   = '0;
                    status   = abort_code;
                end
            end
        endcase

        o_waddr      = ADDR_W'(fill_eff);
        o_ctl.valid  = i_acc;
        o_ctl.status = status;
        if (!i_acc) begin
            o_we = 1'b0;
            o_re = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_frem   <= '0;
            r_active <= '0;
            r_nseq   <= '0;
        end else if (i_acc) begin
            r_fill   <= n_fill;
            r_frem   <= n_frem;
            r_active <= n_active;
            r_nseq   <= n_nseq;
        end
    end

    // header shadow copy; payload data, no reset
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_hdr <= n_hdr;
        end
    end

endmodule

// ===== rtl/afrc_back.sv =====
// Back end: stage that picks up store read data, then a short result queue
// feeding the output stream. Depends on afrc_pkg.
module afrc_back #(
    parameter int MAX_CHUNK = afrc_pkg::MAX_CHUNK_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  afrc_pkg::t_res_ctl                  i_ctl,
    input  logic [$clog2(MAX_CHUNK+1)-1:0]      i_plen,
    input  logic [afrc_pkg::SEQ_W-1:0]          i_seq,
    input  logic [afrc_pkg::BYTE_W-1:0]         i_rdata,
    output logic                                o_ready,
    output logic                                o_valid,
    input  logic                                i_pop_ready,
    output logic [afrc_pkg::STATUS_W-1:0]       o_status,
    output logic [$clog2(MAX_CHUNK+1)-1:0]      o_plen,
    output logic [afrc_pkg::SEQ_W-1:0]          o_seq,
    output logic [afrc_pkg::BYTE_W-1:0]         o_rdata
);

    localparam int PLEN_W = $clog2(MAX_CHUNK + 1);
    localparam int QD     = afrc_pkg::QDEPTH;
    localparam int PW     = afrc_pkg::Q_PTR_W;
    localparam int CW     = afrc_pkg::Q_CNT_W;

    logic                              r_s1_v;
    logic [afrc_pkg::STATUS_W-1:0]     r_s1_status;
    logic [PLEN_W-1:0]                 r_s1_plen;
    logic [afrc_pkg::SEQ_W-1:0]        r_s1_seq;
    logic                              r_s1_hit;

    logic [afrc_pkg::STATUS_W-1:0]     r_q_status [QD];
    logic [PLEN_W-1:0]                 r_q_plen   [QD];
    logic [afrc_pkg::SEQ_W-1:0]        r_q_seq    [QD];
    logic [afrc_pkg::BYTE_W-1:0]       r_q_rdata  [QD];
    logic [PW-1:0]                     r_wp, r_rp;
    logic [CW-1:0]                     r_cnt, n_cnt;
    logic                              push, pop;

    assign push    = r_s1_v;
    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && i_pop_ready;
    // room must cover the beat still in the read stage
    assign o_ready = (r_cnt + CW'(r_s1_v)) < CW'(QD);

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_wp   <= '0;
            r_rp   <= '0;
            r_cnt  <= '0;
        end else begin
            r_s1_v <= i_ctl.valid;
            r_cnt  <= n_cnt;
            if (push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            r_s1_status <= i_ctl.status;
            r_s1_plen   <= i_plen;
            r_s1_seq    <= i_seq;
            r_s1_hit    <= i_ctl.rd_hit;
        end
        if (push) begin
            r_q_status[r_wp] <= r_s1_status;
            r_q_plen[r_wp]   <= r_s1_plen;
            r_q_seq[r_wp]    <= r_s1_seq;
            r_q_rdata[r_wp]  <= r_s1_hit ? i_rdata : '0;
        end
    end

    assign o_status = r_q_status[r_rp];
    assign o_plen   = r_q_plen[r_rp];
    assign o_seq    = r_q_seq[r_rp];
    assign o_rdata  = r_q_rdata[r_rp];

endmodule

// ===== rtl/audio_frame_reassembly_checker_core.sv =====
// Top level of the audio frame reassembly checker: front end, frame store
// and result back end. Depends on afrc_pkg, afrc_front, afrc_ram, afrc_back.
//
// channel   dir  beat contents
// s_axis    in   tuser: req_type, fragment_first; tdata: request fields
// m_axis    out  tuser: status; tdata: payload_length, frame_sequence, read_data
//
// A result reaches m_axis from its request beat on s_axis through the read
// stage register and then the result queue; one request per cycle while m_axis takes.
// Each request is handled by the front end with at most one store access.
// Reset clears stream state and the result queue; the store is not cleared.
// With m_axis stalled, tready drops once queue and read stage hold four beats.
module audio_frame_reassembly_checker_core #(
    parameter int MAX_CHUNK = afrc_pkg::MAX_CHUNK_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tuser: [1:0] req_type, [2] fragment_first
    input  logic [afrc_pkg::IN_USER_W-1:0]        s_axis_tuser,
    // tdata: [15:0] begin_stream_id, [16] playback_active, [32:17] fragment_offset,
    //        [48:33] fragment_length, [64:49] message_length, [72:65] data_value,
    //        [82:73] read_index, rest zero
    input  logic [afrc_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // tuser: [3:0] status
    output logic [afrc_pkg::STATUS_W-1:0]         m_axis_tuser,
    // tdata: payload_length, frame_sequence, read_data from bit 0 up, zero pad
    output logic [(($clog2(MAX_CHUNK+1)+afrc_pkg::SEQ_W+afrc_pkg::BYTE_W+7)/8)*8-1:0]
                                                  m_axis_tdata
);

    localparam int STORE  = afrc_pkg::HDR_BYTES + MAX_CHUNK;
    localparam int ADDR_W = $clog2(STORE);
    localparam int PLEN_W = $clog2(MAX_CHUNK + 1);
    localparam int OUT_W  = ((PLEN_W + afrc_pkg::SEQ_W + afrc_pkg::BYTE_W + 7) / 8) * 8;
    localparam int PAD_W  = OUT_W - PLEN_W - afrc_pkg::SEQ_W - afrc_pkg::BYTE_W;

    afrc_pkg::t_res_ctl               ctl;
    logic                             acc;
    logic [PLEN_W-1:0]                f_plen, b_plen;
    logic [afrc_pkg::SEQ_W-1:0]       f_seq, b_seq;
    logic                             we, re;
    logic [ADDR_W-1:0]                waddr, raddr;
    logic [7:0]                       wdata, rdata, b_rdata;

    assign acc = s_axis_tvalid && s_axis_tready;

    afrc_front #(.MAX_CHUNK(MAX_CHUNK)) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_acc             (acc),
        .i_req_type        (s_axis_tuser[1:0]),
        .i_fragment_first  (s_axis_tuser[2]),
        .i_begin_stream_id (s_axis_tdata[15:0]),
        .i_playback_active (s_axis_tdata[16]),
        .i_fragment_offset (s_axis_tdata[32:17]),
        .i_fragment_length (s_axis_tdata[48:33]),
        .i_message_length  (s_axis_tdata[64:49]),
        .i_data_value      (s_axis_tdata[72:65]),
        .i_read_index      (s_axis_tdata[82:73]),
        .o_ctl             (ctl),
        .o_plen            (f_plen),
        .o_seq             (f_seq),
        .o_we              (we),
        .o_waddr           (waddr),
        .o_wdata           (wdata),
        .o_re              (re),
        .o_raddr           (raddr)
    );

    afrc_ram #(.WIDTH(8), .DEPTH(STORE)) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    afrc_back #(.MAX_CHUNK(MAX_CHUNK)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_plen      (f_plen),
        .i_seq       (f_seq),
        .i_rdata     (rdata),
        .o_ready     (s_axis_tready),
        .o_valid     (m_axis_tvalid),
        .i_pop_ready (m_axis_tready),
        .o_status    (m_axis_tuser),
        .o_plen      (b_plen),
        .o_seq       (b_seq),
        .o_rdata     (b_rdata)
    );

    assign m_axis_tdata = {{PAD_W{1'b0}}, b_rdata, b_seq, b_plen};

endmodule

// ===== rtl/afrc_checker.sv =====
// Port-level checks on the audio frame reassembly checker top level,
// bound to it below. Depends on afrc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module afrc_checker #(
    parameter int MAX_CHUNK = afrc_pkg::MAX_CHUNK_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    input  logic                                  s_axis_tready,
    input  logic [afrc_pkg::IN_USER_W-1:0]        s_axis_tuser,
    input  logic [afrc_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    input  logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    input  logic [afrc_pkg::STATUS_W-1:0]         m_axis_tuser,
    input  logic [(($clog2(MAX_CHUNK+1)+afrc_pkg::SEQ_W+afrc_pkg::BYTE_W+7)/8)*8-1:0]
                                                  m_axis_tdata
);

    localparam int PLEN_W = $clog2(MAX_CHUNK + 1);
    localparam int RD_LO  = PLEN_W + afrc_pkg::SEQ_W;

    // a stalled result beat holds
    `AFRC_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // a waiting request beat holds until it is taken
    `AFRC_ASSERT_NXT(a_in_hold, s_axis_tvalid && !s_axis_tready,
        s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))

    // length and sequence are zero unless the frame is ready
    `AFRC_ASSERT_IMP(a_ready_fields, m_axis_tvalid && m_axis_tuser != afrc_pkg::ST_READY,
        m_axis_tdata[RD_LO-1:0] == '0)

    // read data is zero unless the beat answers a read
    `AFRC_ASSERT_IMP(a_read_field, m_axis_tvalid && m_axis_tuser != afrc_pkg::ST_READ,
        m_axis_tdata[RD_LO+afrc_pkg::BYTE_W-1:RD_LO] == '0)

    // no result straight out of reset
    `AFRC_ASSERT_ALWAYS(a_reset_empty, !$past(i_rst_n), !m_axis_tvalid)

endmodule

bind audio_frame_reassembly_checker_core afrc_checker #(.MAX_CHUNK(MAX_CHUNK)) u_afrc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/sv/frame_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the audio frame reassembly block: tracks accepted request
// beats, predicts frame/store state and compares every result beat.
// Depends on afrc_pkg.
module frame_result_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_valid,
    input  logic                            i_req_ready,
    input  logic [afrc_pkg::IN_USER_W-1:0]  i_req_user,
    input  logic [afrc_pkg::IN_DATA_W-1:0]  i_req_data,
    input  logic                            i_res_valid,
    input  logic                            i_res_ready,
    input  logic [afrc_pkg::STATUS_W-1:0]   i_res_user,
    input  logic [55:0]                     i_res_data,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_store_written
);
    import afrc_pkg::*;

    localparam int STORE_BYTES = HDR_BYTES + MAX_CHUNK_DEF;
    localparam int PLEN_W      = $clog2(MAX_CHUNK_DEF + 1);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PLEN_W-1:0]   plen;
        logic [SEQ_W-1:0]    seq;
        logic [BYTE_W-1:0]   rdata;
    } t_frame_result;

    t_frame_result frame_verdicts[$];

    logic [7:0]  frame_mem [0:STORE_BYTES-1];
    int unsigned fill;
    int unsigned remaining;
    logic [15:0] active_sid;
    logic [31:0] next_seq;
    int          written_hw;
    int          mismatches;

    assign o_fail_count = mismatches;

    initial begin
        mismatches = 0;
        written_hw = 0;
        o_pending = 0;
        o_store_written = 0;
        for (int i = 0; i < STORE_BYTES; i++) frame_mem[i] = 8'h00;
    end

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatches++;
        $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    function automatic logic [STATUS_W-1:0] drop_stream(input logic [STATUS_W-1:0] code);
        active_sid = '0;
        fill = 0;
        remaining = 0;
        return code;
    endfunction

    task automatic reassemble_step(input logic [IN_USER_W-1:0] user,
                                   input logic [IN_DATA_W-1:0] d);
        logic [1:0]    req;
        logic          first;
        logic [15:0]   bsid;
        logic          play;
        int unsigned   foff, flen, mlen, ridx, done_len;
        logic [7:0]    data_b;
        logic          take;
        logic [15:0]   sid;
        logic [31:0]   seq;
        t_frame_result r;

        req    = user[1:0];
        first  = user[2];
        bsid   = d[15:0];
        play   = d[16];
        foff   = d[32:17];
        flen   = d[48:33];
        mlen   = d[64:49];
        data_b = d[72:65];
        ridx   = d[82:73];
        r      = '0;
        r.status = ST_IGNORED;
        take   = 1'b0;

        case (req)
            REQ_BEGIN: begin
                if (bsid != 16'd0) begin
                    active_sid = bsid;
                    next_seq = '0;
                    fill = 0;
                    remaining = 0;
                    r.status = ST_STARTED;
                end
            end
            REQ_STOP: begin
                // fill is kept on purpose
                active_sid = '0;
                remaining = 0;
                r.status = ST_STOPPED;
            end
            REQ_READ: begin
                r.status = ST_READ;
                if (ridx < MAX_CHUNK_DEF) r.rdata = frame_mem[HDR_BYTES + ridx];
            end
            default: begin
                if (first) begin
                    if (!play || active_sid == 16'd0) begin
                        remaining = 0;
                    end else if (mlen < MIN_FRAME || mlen > STORE_BYTES) begin
                        r.status = drop_stream(ST_BOUNDS);
                    end else begin
                        if (foff == 0) fill = 0;
                        if (foff != fill) r.status = drop_stream(ST_DESYNC);
                        else if (fill + flen > STORE_BYTES) r.status = drop_stream(ST_BOUNDS);
                        else if (flen != 0) begin
                            remaining = flen;
                            take = 1'b1;
                        end
                    end
                end else if (remaining != 0) begin
                    take = 1'b1;
                end

                if (take && fill < STORE_BYTES) begin
                    frame_mem[fill] = data_b;
                    fill++;
                    if (fill > written_hw) written_hw = fill;
                    remaining--;
                    r.status = ST_TAKEN;
                    if (remaining == 0 && fill >= mlen) begin
                        done_len = fill;
                        fill = 0;
                        sid = {frame_mem[3], frame_mem[2]};
                        seq = {frame_mem[7], frame_mem[6], frame_mem[5], frame_mem[4]};
                        if (frame_mem[0] != MAGIC_A || frame_mem[1] != MAGIC_B)
                            r.status = drop_stream(ST_MAGIC);
                        else if (sid != active_sid)
                            r.status = drop_stream(ST_STREAM);
                        else if (seq != next_seq)
                            r.status = drop_stream(ST_SEQ);
                        else begin
                            next_seq++;
                            r.status = ST_READY;
                            r.plen = PLEN_W'(done_len - HDR_BYTES);
                            r.seq = seq;
                        end
                    end
                end else if (take) begin
                    r.status = drop_stream(ST_BOUNDS);
                end
            end
        endcase
        frame_verdicts.push_back(r);
    endtask

    task automatic check_result(input logic [STATUS_W-1:0] status, input logic [55:0] d);
        t_frame_result want;
        logic [PLEN_W-1:0] plen;
        logic [SEQ_W-1:0]  seq;
        logic [BYTE_W-1:0] rdata;

        plen  = d[PLEN_W-1:0];
        seq   = d[PLEN_W+SEQ_W-1:PLEN_W];
        rdata = d[PLEN_W+SEQ_W+BYTE_W-1:PLEN_W+SEQ_W];
        if (frame_verdicts.size() == 0) begin
            note_mismatch("unexpected result beat, status", 32'(status), 32'(ST_IGNORED));
        end else begin
            want = frame_verdicts.pop_front();
            if (status !== want.status) note_mismatch("status", 32'(status), 32'(want.status));
            if (plen !== want.plen) note_mismatch("payload_length", 32'(plen), 32'(want.plen));
            if (seq !== want.seq) note_mismatch("frame_sequence", seq, want.seq);
            if (rdata !== want.rdata) note_mismatch("read_data", 32'(rdata), 32'(want.rdata));
        end
    endtask

    // request first, so a result in the same cycle as its request would still find its entry
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fill = 0;
            remaining = 0;
            active_sid = '0;
            next_seq = '0;
            frame_verdicts.delete();
        end else begin
            if (i_req_valid && i_req_ready) reassemble_step(i_req_user, i_req_data);
            if (i_res_valid && i_res_ready) check_result(i_res_user, i_res_data);
        end
        o_pending <= frame_verdicts.size();
        o_store_written <= written_hw;
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Top of the audio frame reassembly testbench: clock, reset, request stimulus
// and output backpressure. Depends on afrc_pkg, the core and frame_result_checker.
module testbench;
    import afrc_pkg::*;

    localparam int STORE_BYTES = HDR_BYTES + MAX_CHUNK_DEF;
    localparam int OUT_DATA_W  = (($clog2(MAX_CHUNK_DEF + 1) + SEQ_W + BYTE_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEM_TARGET = 1350;

    typedef enum {
        FRAME_CLEAN,
        FRAME_BAD_MAGIC,
        FRAME_BAD_SID,
        FRAME_BAD_SEQ,
        FRAME_BAD_OFFSET,
        FRAME_BAD_LEN,
        FRAME_NO_PLAY,
        FRAME_STOPPED
    } t_frame_fault;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_USER_W-1:0]   s_axis_tuser;
    logic [IN_DATA_W-1:0]   s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [STATUS_W-1:0]    m_axis_tuser;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;

    int          fail_count;
    int          pending;
    int          store_hw;
    int          cycles;
    int          beats_sent;
    logic        quiet;
    logic        stream_ok;
    logic [15:0] cur_sid;
    logic [31:0] cur_seq;

    audio_frame_reassembly_checker_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tdata  (m_axis_tdata)
    );

    frame_result_checker u_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (s_axis_tvalid),
        .i_req_ready     (s_axis_tready),
        .i_req_user      (s_axis_tuser),
        .i_req_data      (s_axis_tdata),
        .i_res_valid     (m_axis_tvalid),
        .i_res_ready     (m_axis_tready),
        .i_res_user      (m_axis_tuser),
        .i_res_data      (m_axis_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_store_written (store_hw)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk)
        m_axis_tready <= quiet || ($urandom_range(0, 99) >= 29);

    function automatic logic [IN_DATA_W-1:0] pack_req(
        input logic [15:0] bsid, input logic play, input logic [15:0] foff,
        input logic [15:0] flen, input logic [15:0] mlen, input logic [7:0] dv,
        input logic [9:0] ridx);
        return {5'b0, ridx, dv, mlen, flen, foff, play, bsid};
    endfunction

    // Holds the beat until the handshake; tready is sampled at the falling edge.
    task automatic send_beat(input logic [1:0] req, input logic first,
                             input logic [IN_DATA_W-1:0] data);
        logic ok;
        while (!quiet && $urandom_range(0, 99) < 29) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= {first, req};
        s_axis_tdata  <= data;
        do begin
            @(negedge i_clk);
            ok = s_axis_tready;
            @(posedge i_clk);
        end while (!ok);
        beats_sent++;
    endtask

    task automatic send_begin(input logic [15:0] sid);
        send_beat(REQ_BEGIN, 1'($urandom),
                  pack_req(sid, 1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                           8'($urandom), 10'($urandom)));
        cur_sid = sid;
        cur_seq = '0;
        stream_ok = 1'b1;
    endtask

    task automatic send_stop();
        send_beat(REQ_STOP, 1'($urandom),
                  pack_req(16'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom), 8'($urandom), 10'($urandom)));
        stream_ok = 1'b0;
    endtask

    // Only indices inside the already written part of the store.
    task automatic send_read(input int idx);
        send_beat(REQ_READ, 1'($urandom),
                  pack_req(16'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom), 8'($urandom), 10'(idx)));
    endtask

    task automatic read_random();
        if (store_hw > HDR_BYTES) send_read($urandom_range(0, store_hw - HDR_BYTES - 1));
    endtask

    task automatic send_frame(input int plen, input t_frame_fault fault);
        logic [7:0]  fb [$];
        logic [15:0] sid;
        logic [31:0] seq;
        logic [15:0] foff_v, mlen_v;
        logic        play;
        int          len, pos, chunk, declared, stop_at;

        len = HDR_BYTES + plen;
        sid = (fault == FRAME_BAD_SID) ? cur_sid ^ 16'($urandom_range(1, 65535)) : cur_sid;
        seq = (fault == FRAME_BAD_SEQ) ? cur_seq + $urandom_range(1, 32'hFFFF_FFFE) : cur_seq;
        fb.push_back(MAGIC_A);
        fb.push_back(MAGIC_B);
        fb.push_back(sid[7:0]);
        fb.push_back(sid[15:8]);
        fb.push_back(seq[7:0]);
        fb.push_back(seq[15:8]);
        fb.push_back(seq[23:16]);
        fb.push_back(seq[31:24]);
        for (int i = 0; i < plen; i++) fb.push_back(8'($urandom));
        if (fault == FRAME_BAD_MAGIC) begin
            pos = $urandom_range(0, 1);
            fb[pos] = fb[pos] ^ 8'($urandom_range(1, 255));
        end
        stop_at = (fault == FRAME_STOPPED) ? $urandom_range(1, len - 1) : -1;

        pos = 0;
        while (pos < len) begin
            chunk = $urandom_range(0, 1) ? len - pos : $urandom_range(1, len - pos);
            declared = chunk;
            // fragment cut short: the next fragment starts before this one ends
            if (pos + chunk + 4 < len && $urandom_range(0, 9) == 0)
                declared = chunk + $urandom_range(1, 4);
            for (int i = 0; i < chunk; i++) begin
                if (pos + i == stop_at) send_stop();
                if (i == 0) begin
                    foff_v = 16'(pos);
                    mlen_v = 16'(len);
                    play = 1'b1;
                    if (fault == FRAME_BAD_OFFSET) foff_v = 16'(pos + $urandom_range(1, 300));
                    if (fault == FRAME_BAD_LEN && pos == 0)
                        mlen_v = $urandom_range(0, 1) ? 16'($urandom_range(0, MIN_FRAME - 1))
                                 : 16'($urandom_range(STORE_BYTES + 1, 65535));
                    if (fault == FRAME_NO_PLAY && pos == 0) play = 1'b0;
                    send_beat(REQ_DATA, 1'b1,
                              pack_req(16'($urandom), play, foff_v, 16'(declared), mlen_v,
                                       fb[pos], 10'($urandom)));
                end else begin
                    send_beat(REQ_DATA, 1'b0,
                              pack_req(16'($urandom), 1'($urandom), 16'($urandom),
                                       16'($urandom), 16'(len), fb[pos + i], 10'($urandom)));
                end
            end
            pos += chunk;
        end
        if (fault == FRAME_CLEAN) cur_seq++;
        else stream_ok = 1'b0;
    endtask

    task automatic send_noise();
        logic [1:0] req;
        req = 2'($urandom_range(0, 3));
        case (req)
            REQ_BEGIN: send_begin(16'($urandom_range(1, 65535)));
            REQ_STOP:  send_stop();
            REQ_READ:  read_random();
            default:   send_beat(REQ_DATA, 1'($urandom),
                                 pack_req(16'($urandom), 1'($urandom), 16'($urandom),
                                          16'($urandom_range(1, 65535)), 16'($urandom),
                                          8'($urandom), 10'($urandom)));
        endcase
        stream_ok = 1'b0;
    endtask

    initial begin
        int pick;
        int start;

        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = '0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cycles = 0;
        beats_sent = 0;
        quiet = 1'b0;
        stream_ok = 1'b0;
        cur_sid = '0;
        cur_seq = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: gate, stray byte, bounds and desync aborts, minimal frame
        send_beat(REQ_DATA, 1'b1, pack_req(16'h0, 1'b1, 16'h0, 16'd10, 16'd0, 8'h00, 10'h0));
        send_begin(16'hFFFF);
        send_beat(REQ_DATA, 1'b0, pack_req(16'h0, 1'b1, 16'h0, 16'd1, 16'd10, 8'hFF, 10'h3FF));
        send_beat(REQ_DATA, 1'b1, pack_req(16'h0, 1'b0, 16'h0, 16'd10, 16'd10, 8'h4A, 10'h0));
        send_beat(REQ_DATA, 1'b1,
                  pack_req(16'h0, 1'b1, 16'h0, 16'd10, 16'(MIN_FRAME - 1), 8'h4A, 10'h0));
        send_begin(16'h0001);
        send_beat(REQ_DATA, 1'b1,
                  pack_req(16'h0, 1'b1, 16'h0, 16'd10, 16'(STORE_BYTES + 1), 8'h4A, 10'h0));
        send_begin(16'hFFFF);
        send_beat(REQ_DATA, 1'b1,
                  pack_req(16'hFFFF, 1'b1, 16'hFFFF, 16'd10, 16'd10, 8'h4A, 10'h0));
        send_begin(16'hFFFF);
        send_beat(REQ_DATA, 1'b1,
                  pack_req(16'h0, 1'b1, 16'h0, 16'hFFFF, 16'(STORE_BYTES), 8'h4A, 10'h0));
        send_begin(16'hFFFF);
        send_frame(2, FRAME_CLEAN);
        send_read(0);
        send_read(1);
        send_stop();

        // largest frame first, so the whole payload area becomes readable
        send_begin(16'($urandom_range(1, 65535)));
        send_frame(MAX_CHUNK_DEF, FRAME_CLEAN);
        send_read(MAX_CHUNK_DEF - 1);
        send_read(MAX_CHUNK_DEF / 2);

        start = beats_sent;
        while (beats_sent < ITEM_TARGET) begin
            quiet = (beats_sent - start >= 60) && (beats_sent - start < 200);
            if (!stream_ok) send_begin(16'($urandom_range(1, 65535)));
            pick = $urandom_range(0, 99);
            if (pick < 60)
                send_frame(($urandom_range(0, 9) == 0) ? $urandom_range(2, 200)
                                                         : $urandom_range(2, 40), FRAME_CLEAN);
            else if (pick < 72)
                send_frame($urandom_range(2, 40), t_frame_fault'($urandom_range(1, 7)));
            else if (pick < 84)
                repeat ($urandom_range(1, 6)) read_random();
            else if (pick < 88)
                send_stop();
            else if (pick < 92)
                send_begin(16'($urandom_range(1, 65535)));
            else
                repeat ($urandom_range(1, 4)) send_noise();
        end
        quiet = 1'b0;
        s_axis_tvalid <= 1'b0;

        // let the last handshake reach the pending count first
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/afrc_pkg.sv
rtl/afrc_ram.sv
rtl/afrc_front.sv
rtl/afrc_back.sv
rtl/audio_frame_reassembly_checker_core.sv
rtl/afrc_checker.sv
tb/sv/frame_result_checker.sv
tb/sv/testbench.sv
